### src/sc1kd_pkg.sv
// ----------------------------------------------------------------------------
// Scan code set 1 key event decoder package
// Shared types, constants and key tables of the decoder.
// ----------------------------------------------------------------------------
package sc1kd_pkg;

   localparam int BUFFER_SLOTS_DEFAULT = 16;

   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [7:0] SC_PREFIX      = 8'hE0;
   localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
   localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
   localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;
   localparam logic [7:0] SC_ALT_MAKE    = 8'h38;
   localparam logic [7:0] SC_ALT_BRK     = 8'hB8;
   localparam logic [7:0] SC_CAPS        = 8'h3A;

   localparam logic [6:0] CHR_LOWER_A = 7'h61;
   localparam logic [6:0] CHR_LOWER_Z = 7'h7A;
   localparam logic [6:0] CHR_UPPER_A = 7'h41;
   localparam logic [6:0] CHR_UPPER_Z = 7'h5A;
   localparam logic [6:0] CTRL_LOWER_OFS = 7'h60;
   localparam logic [6:0] CTRL_UPPER_OFS = 7'h40;

   localparam logic [6:0] PLAIN_MAP [64] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   localparam logic [6:0] SHIFT_MAP [64] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   typedef struct packed {
      logic       op;
      logic       has_event;
      logic [7:0] ev_scan;
      logic [6:0] ev_ascii;
      logic [3:0] mods;
   } cmd_type;

endpackage

### src/scancode_set1_key_event_decoder_unit.sv
// ----------------------------------------------------------------------------
// Scan code set 1 key event decoder
// Decodes set 1 scan code bytes into key events held in a ring, and pops them.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata                                   tuser
// req      in         scan_byte[7:0]                          op
// rsp      out        scan, ascii, queued, dropped, avail,    event_valid
//                     modifier_bits
//
// One beat is accepted per cycle while the command queue has room; a result
// passes through the command queue, then the result register at the ring.
// Back-pressure on the result channel, through the command queue, sets the rate.
// Reset is synchronous and empties the ring and clears all modifiers.
// A stalled result fills the two-entry queue, after which req_tready drops.
// ----------------------------------------------------------------------------
module scancode_set1_key_event_decoder_unit #(
   parameter int BUFFER_SLOTS = sc1kd_pkg::BUFFER_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // scan_byte[7:0]
   input  logic [0:0]  req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // event_scan[7:0], event_ascii[14:8],
                                    // event_queued[15], event_dropped[16],
                                    // available[17], modifier_bits[21:18], zero
   output logic [0:0]  rsp_tuser    // event_valid[0]
);

   sc1kd_pkg::cmd_type front_cmd, back_cmd;
   logic front_valid, front_ready, back_valid, back_ready;
   logic       ev_valid, ev_queued, ev_dropped, avail;
   logic [7:0] ev_scan;
   logic [6:0] ev_ascii;
   logic [3:0] mods;

   sc1kd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser[0]),
      .in_scan   (req_tdata),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   sc1kd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   sc1kd_back #(
      .BUFFER_SLOTS (BUFFER_SLOTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (back_valid),
      .cmd_ready         (back_ready),
      .cmd               (back_cmd),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_event_valid   (ev_valid),
      .out_event_scan    (ev_scan),
      .out_event_ascii   (ev_ascii),
      .out_event_queued  (ev_queued),
      .out_event_dropped (ev_dropped),
      .out_available     (avail),
      .out_modifier_bits (mods)
   );

   assign rsp_tdata = {2'b00, mods, avail, ev_dropped, ev_queued, ev_ascii, ev_scan};
   assign rsp_tuser = ev_valid;

endmodule

### src/sc1kd_front.sv
// ----------------------------------------------------------------------------
// Scan code set 1 decoder front end
// Tracks prefix and modifier state and turns each beat into a ring command.
// ----------------------------------------------------------------------------
module sc1kd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_op,
   input  logic [7:0]          in_scan,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output sc1kd_pkg::cmd_type  cmd
);

   logic ext_ff, shift_ff, ctrl_ff, alt_ff, caps_ff;
   logic ext_in, shift_in, ctrl_in, alt_in, caps_in;
   logic       has_event;
   logic [7:0] ev_scan;
   logic [6:0] ev_ascii;
   logic [6:0] chr;
   logic       is_lower, is_upper, is_shift_code;
   logic       accept;

   assign in_ready  = cmd_ready;
   assign cmd_valid = in_valid;
   assign accept    = in_valid & cmd_ready;

   always_comb begin
      chr = shift_ff ? sc1kd_pkg::SHIFT_MAP[in_scan[5:0]]
                     : sc1kd_pkg::PLAIN_MAP[in_scan[5:0]];
      if (in_scan[6]) begin
         chr = 7'd0;
      end
      if (caps_ff && chr >= sc1kd_pkg::CHR_LOWER_A && chr <= sc1kd_pkg::CHR_LOWER_Z) begin
         chr[5] = 1'b0;
      end else if (caps_ff && chr >= sc1kd_pkg::CHR_UPPER_A &&
                   chr <= sc1kd_pkg::CHR_UPPER_Z) begin
         chr[5] = 1'b1;
      end
      is_lower = (chr >= sc1kd_pkg::CHR_LOWER_A) && (chr <= sc1kd_pkg::CHR_LOWER_Z);
      is_upper = (chr >= sc1kd_pkg::CHR_UPPER_A) && (chr <= sc1kd_pkg::CHR_UPPER_Z);
      is_shift_code = (in_scan == sc1kd_pkg::SC_LSHIFT_MAKE) ||
                      (in_scan == sc1kd_pkg::SC_RSHIFT_MAKE) ||
                      (in_scan == sc1kd_pkg::SC_LSHIFT_BRK) ||
                      (in_scan == sc1kd_pkg::SC_RSHIFT_BRK);

      ext_in    = 1'b0;
      shift_in  = shift_ff;
      ctrl_in   = ctrl_ff;
      alt_in    = alt_ff;
      caps_in   = caps_ff;
      has_event = 1'b0;
      ev_scan   = 8'd0;
      ev_ascii  = 7'd0;

      if (in_op == sc1kd_pkg::OP_POP) begin
         ext_in = ext_ff;
      end else if (in_scan == sc1kd_pkg::SC_PREFIX) begin
         ext_in = 1'b1;
      end else if (ext_ff && is_shift_code) begin
         ext_in = 1'b0;
      end else if (in_scan == sc1kd_pkg::SC_LSHIFT_MAKE ||
                   in_scan == sc1kd_pkg::SC_RSHIFT_MAKE) begin
         shift_in = 1'b1;
      end else if (in_scan == sc1kd_pkg::SC_LSHIFT_BRK ||
                   in_scan == sc1kd_pkg::SC_RSHIFT_BRK) begin
         shift_in = 1'b0;
      end else if (in_scan == sc1kd_pkg::SC_CTRL_MAKE) begin
         ctrl_in = 1'b1;
      end else if (in_scan == sc1kd_pkg::SC_CTRL_BRK) begin
         ctrl_in = 1'b0;
      end else if (in_scan == sc1kd_pkg::SC_ALT_MAKE) begin
         alt_in = 1'b1;
      end else if (in_scan == sc1kd_pkg::SC_ALT_BRK) begin
         alt_in = 1'b0;
      end else if (in_scan == sc1kd_pkg::SC_CAPS) begin
         caps_in = ~caps_ff;
      end else if (!in_scan[7]) begin
         has_event = 1'b1;
         if (ext_ff || alt_ff || chr == 7'd0) begin
            ev_scan = in_scan;
         end else if (ctrl_ff && is_lower) begin
            ev_ascii = chr - sc1kd_pkg::CTRL_LOWER_OFS;
         end else if (ctrl_ff && is_upper) begin
            ev_ascii = chr - sc1kd_pkg::CTRL_UPPER_OFS;
         end else begin
            ev_ascii = chr;
         end
      end

      cmd.op        = in_op;
      cmd.has_event = has_event;
      cmd.ev_scan   = ev_scan;
      cmd.ev_ascii  = ev_ascii;
      cmd.mods      = {alt_in, ctrl_in, shift_in, shift_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff   <= 1'b0;
         shift_ff <= 1'b0;
         ctrl_ff  <= 1'b0;
         alt_ff   <= 1'b0;
         caps_ff  <= 1'b0;
      end else if (accept) begin
         ext_ff   <= ext_in;
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         alt_ff   <= alt_in;
         caps_ff  <= caps_in;
      end
   end

endmodule

### src/sc1kd_queue.sv
// ----------------------------------------------------------------------------
// Scan code set 1 decoder command queue
// Two-entry queue that decouples the front end from the ring back end.
// ----------------------------------------------------------------------------
module sc1kd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  sc1kd_pkg::cmd_type  push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output sc1kd_pkg::cmd_type  pop_cmd
);

   sc1kd_pkg::cmd_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ff, rd_ff;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ff <= ~wr_ff;
         end
         if (do_pop) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

### src/sc1kd_back.sv
// ----------------------------------------------------------------------------
// Scan code set 1 decoder ring back end
// Event ring with one empty slot, and the registered result beat.
// ----------------------------------------------------------------------------
module sc1kd_back #(
   parameter int BUFFER_SLOTS = sc1kd_pkg::BUFFER_SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  sc1kd_pkg::cmd_type  cmd,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_event_valid,
   output logic [7:0]          out_event_scan,
   output logic [6:0]          out_event_ascii,
   output logic                out_event_queued,
   output logic                out_event_dropped,
   output logic                out_available,
   output logic [3:0]          out_modifier_bits
);

   localparam int IW = (BUFFER_SLOTS > 2) ? $clog2(BUFFER_SLOTS) : 1;
   localparam logic [IW-1:0] LAST_SLOT = IW'(BUFFER_SLOTS - 1);

   logic [14:0]   event_store_ff [BUFFER_SLOTS];
   logic [14:0]   rd_data_ff;
   logic [IW-1:0] wr_ff, rd_ff, wr_in, rd_in, wr_next, rd_next;
   logic          valid_ff, ev_valid_ff, queued_ff, dropped_ff, avail_ff;
   logic          ev_valid_in, queued_in, dropped_in;
   logic [3:0]    mods_ff;
   logic          take, do_write, do_read, is_full, is_empty;

   assign cmd_ready = ~valid_ff | out_ready;
   assign take      = cmd_valid & cmd_ready;
   assign wr_next   = (wr_ff == LAST_SLOT) ? '0 : wr_ff + IW'(1);
   assign rd_next   = (rd_ff == LAST_SLOT) ? '0 : rd_ff + IW'(1);
   assign is_full   = (wr_next == rd_ff);
   assign is_empty  = (wr_ff == rd_ff);

   always_comb begin
      wr_in       = wr_ff;
      rd_in       = rd_ff;
      ev_valid_in = 1'b0;
      queued_in   = 1'b0;
      dropped_in  = 1'b0;
      do_write    = 1'b0;
      do_read     = 1'b0;
      if (cmd.op == sc1kd_pkg::OP_POP) begin
         if (!is_empty) begin
            ev_valid_in = 1'b1;
            do_read     = take;
            rd_in       = rd_next;
         end
      end else if (cmd.has_event) begin
         if (is_full) begin
            dropped_in = 1'b1;
         end else begin
            queued_in = 1'b1;
            do_write  = take;
            wr_in     = wr_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         wr_ff    <= '0;
         rd_ff    <= '0;
      end else begin
         if (take) begin
            valid_ff <= 1'b1;
            wr_ff    <= wr_in;
            rd_ff    <= rd_in;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ev_valid_ff <= ev_valid_in;
         queued_ff   <= queued_in;
         dropped_ff  <= dropped_in;
         avail_ff    <= (wr_in != rd_in);
         mods_ff     <= cmd.mods;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         event_store_ff[wr_ff] <= {cmd.ev_scan, cmd.ev_ascii};
      end
      if (do_read) begin
         rd_data_ff <= event_store_ff[rd_ff];
      end
   end

   assign out_valid         = valid_ff;
   assign out_event_valid   = ev_valid_ff;
   assign out_event_scan    = ev_valid_ff ? rd_data_ff[14:7] : 8'd0;
   assign out_event_ascii   = ev_valid_ff ? rd_data_ff[6:0] : 7'd0;
   assign out_event_queued  = queued_ff;
   assign out_event_dropped = dropped_ff;
   assign out_available     = avail_ff;
   assign out_modifier_bits = mods_ff;

endmodule

### test/scancode_set1_key_event_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scan code set 1 key event decoder testbench
// Feeds scan code and pop beats with random gaps and result back-pressure.
// A scoreboard tracks the modifiers, the E0 prefix and the event ring.
// It predicts every result beat and compares each field of the beat.
// ----------------------------------------------------------------------------

typedef struct {
   logic       valid;
   logic [7:0] scan;
   logic [6:0] ascii;
   logic       queued;
   logic       dropped;
   logic       avail;
   logic [3:0] mods;
} key_result_type;

class key_event_scoreboard;
   localparam int SLOTS = sc1kd_pkg::BUFFER_SLOTS_DEFAULT;

   bit [6:0] plain_chars [64] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };
   bit [6:0] shifted_chars [64] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   bit [15:0]      ring [SLOTS];
   int             wr_ptr;
   int             rd_ptr;
   bit             shift_down;
   bit             ctrl_down;
   bit             alt_down;
   bit             caps_lock;
   bit             prefix_seen;
   key_result_type results_due [$];
   int             errors;
   int             scan_beats;
   int             pop_beats;
   int             events_queued;
   int             events_dropped;
   int             events_popped;
   int             ring_fills;

   function bit [6:0] key_char(bit [7:0] sc);
      bit [6:0] c;
      if (sc >= 8'd64) begin
         c = 7'h00;
      end else if (shift_down) begin
         c = shifted_chars[sc[5:0]];
      end else begin
         c = plain_chars[sc[5:0]];
      end
      if (caps_lock && c >= sc1kd_pkg::CHR_LOWER_A && c <= sc1kd_pkg::CHR_LOWER_Z) begin
         c = c - 7'd32;
      end else if (caps_lock && c >= sc1kd_pkg::CHR_UPPER_A &&
                   c <= sc1kd_pkg::CHR_UPPER_Z) begin
         c = c + 7'd32;
      end
      return c;
   endfunction

   // Returns -1 when the byte makes no key event.
   function int decode_key(bit [7:0] sc);
      bit       was_prefixed;
      bit [6:0] c;
      was_prefixed = prefix_seen;
      if (sc == sc1kd_pkg::SC_PREFIX) begin
         prefix_seen = 1'b1;
         return -1;
      end
      prefix_seen = 1'b0;
      if (was_prefixed && (sc == sc1kd_pkg::SC_LSHIFT_MAKE ||
                           sc == sc1kd_pkg::SC_RSHIFT_MAKE ||
                           sc == sc1kd_pkg::SC_LSHIFT_BRK ||
                           sc == sc1kd_pkg::SC_RSHIFT_BRK)) begin
         return -1;
      end
      case (sc)
         sc1kd_pkg::SC_LSHIFT_MAKE, sc1kd_pkg::SC_RSHIFT_MAKE: begin
            shift_down = 1'b1;
            return -1;
         end
         sc1kd_pkg::SC_LSHIFT_BRK, sc1kd_pkg::SC_RSHIFT_BRK: begin
            shift_down = 1'b0;
            return -1;
         end
         sc1kd_pkg::SC_CTRL_MAKE: begin ctrl_down = 1'b1; return -1; end
         sc1kd_pkg::SC_CTRL_BRK:  begin ctrl_down = 1'b0; return -1; end
         sc1kd_pkg::SC_ALT_MAKE:  begin alt_down = 1'b1; return -1; end
         sc1kd_pkg::SC_ALT_BRK:   begin alt_down = 1'b0; return -1; end
         sc1kd_pkg::SC_CAPS:      begin caps_lock = !caps_lock; return -1; end
         default: ;
      endcase
      if (sc[7]) begin
         return -1;
      end
      if (was_prefixed || alt_down) begin
         return int'({sc, 8'h00});
      end
      c = key_char(sc);
      if (c == 7'h00) begin
         return int'({sc, 8'h00});
      end
      if (ctrl_down && c >= sc1kd_pkg::CHR_LOWER_A && c <= sc1kd_pkg::CHR_LOWER_Z) begin
         return int'(c - sc1kd_pkg::CTRL_LOWER_OFS);
      end
      if (ctrl_down && c >= sc1kd_pkg::CHR_UPPER_A && c <= sc1kd_pkg::CHR_UPPER_Z) begin
         return int'(c - sc1kd_pkg::CTRL_UPPER_OFS);
      end
      return int'(c);
   endfunction

   function void note_beat(bit op, bit [7:0] sc);
      key_result_type r;
      int             ev;
      int             nxt;
      r = '{valid: 1'b0, scan: 8'h00, ascii: 7'h00, queued: 1'b0,
            dropped: 1'b0, avail: 1'b0, mods: 4'h0};
      if (op == sc1kd_pkg::OP_POP) begin
         pop_beats++;
         if (wr_ptr != rd_ptr) begin
            r.valid = 1'b1;
            r.scan  = ring[rd_ptr][15:8];
            r.ascii = ring[rd_ptr][6:0];
            rd_ptr  = (rd_ptr + 1) % SLOTS;
            events_popped++;
         end
      end else begin
         scan_beats++;
         ev = decode_key(sc);
         if (ev >= 0) begin
            nxt = (wr_ptr + 1) % SLOTS;
            if (nxt == rd_ptr) begin
               r.dropped = 1'b1;
               events_dropped++;
            end else begin
               ring[wr_ptr] = ev[15:0];
               wr_ptr = nxt;
               r.queued = 1'b1;
               events_queued++;
               if ((nxt + 1) % SLOTS == rd_ptr) begin
                  ring_fills++;
               end
            end
         end
      end
      r.avail = (wr_ptr != rd_ptr);
      r.mods  = {alt_down, ctrl_down, shift_down, shift_down};
      results_due.push_back(r);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   function void check_beat(logic [23:0] data, logic [0:0] user);
      key_result_type want;
      if (results_due.size() == 0) begin
         $error("result beat 0x%h arrived with no result expected", data);
         errors++;
         return;
      end
      want = results_due.pop_front();
      compare_field("event_valid", want.valid, user[0]);
      compare_field("event_scan", want.scan, data[7:0]);
      compare_field("event_ascii", want.ascii, data[14:8]);
      compare_field("event_queued", want.queued, data[15]);
      compare_field("event_dropped", want.dropped, data[16]);
      compare_field("available", want.avail, data[17]);
      compare_field("modifier_bits", want.mods, data[21:18]);
      compare_field("tdata padding", 0, data[23:22]);
   endfunction
endclass

module scancode_set1_key_event_decoder_unit_tb;

   localparam int  RANDOM_BEATS = 700;
   localparam int  QUIET_BEATS  = 120;
   localparam int  CYCLE_LIMIT  = 200000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   key_event_scoreboard sb = new();
   bit                  quiet_phase;
   int                  beats_sent;
   int                  cycle_count = 0;

   scancode_set1_key_event_decoder_unit #(
      .BUFFER_SLOTS(sc1kd_pkg::BUFFER_SLOTS_DEFAULT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_beat(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   task automatic send_beat(bit op, bit [7:0] sc);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = sc;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_beat(op, sc);
      beats_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.results_due.size() != 0) @(posedge clock);
   endtask

   // One keyboard action: mostly well-formed make and break sequences.
   task automatic type_key();
      bit [7:0] code;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         code = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 127))
                                            : 8'($urandom_range(1, 8'h39));
         send_beat(sc1kd_pkg::OP_SCAN, code);
         if ($urandom_range(0, 9) < 7) begin
            send_beat(sc1kd_pkg::OP_SCAN, code | 8'h80);
         end
      end else if (pick < 62) begin
         case ($urandom_range(0, 3))
            0: code = sc1kd_pkg::SC_LSHIFT_MAKE;
            1: code = sc1kd_pkg::SC_RSHIFT_MAKE;
            2: code = sc1kd_pkg::SC_CTRL_MAKE;
            default: code = sc1kd_pkg::SC_ALT_MAKE;
         endcase
         if ($urandom_range(0, 1) == 1) begin
            code = code | 8'h80;
         end
         if ((code & 8'h7F) != sc1kd_pkg::SC_LSHIFT_MAKE &&
             (code & 8'h7F) != sc1kd_pkg::SC_RSHIFT_MAKE &&
             $urandom_range(0, 2) == 0) begin
            send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_PREFIX);
         end
         send_beat(sc1kd_pkg::OP_SCAN, code);
      end else if (pick < 68) begin
         send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_CAPS);
         send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_CAPS | 8'h80);
      end else if (pick < 80) begin
         code = 8'($urandom_range(0, 127));
         send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_PREFIX);
         send_beat(sc1kd_pkg::OP_SCAN, code);
         if ($urandom_range(0, 1) == 1) begin
            send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_PREFIX);
            send_beat(sc1kd_pkg::OP_SCAN, code | 8'h80);
         end
      end else if (pick < 88) begin
         send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_PREFIX);
         case ($urandom_range(0, 3))
            0: send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_LSHIFT_MAKE);
            1: send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_RSHIFT_MAKE);
            2: send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_LSHIFT_BRK);
            default: send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_RSHIFT_BRK);
         endcase
      end else begin
         send_beat(sc1kd_pkg::OP_SCAN, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int  random_end;
      int  pop_percent;
      int  segment_start;
      bit  drained_once;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tuser   = sc1kd_pkg::OP_SCAN;
      quiet_phase = 1'b0;
      beats_sent  = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_beat(sc1kd_pkg::OP_POP, 8'hFF);
      send_beat(sc1kd_pkg::OP_SCAN, 8'h00);
      send_beat(sc1kd_pkg::OP_SCAN, 8'h1E);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_LSHIFT_MAKE);
      send_beat(sc1kd_pkg::OP_SCAN, 8'h02);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_CAPS);
      send_beat(sc1kd_pkg::OP_SCAN, 8'h1E);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_LSHIFT_BRK);
      send_beat(sc1kd_pkg::OP_SCAN, 8'h1E);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_CTRL_MAKE);
      send_beat(sc1kd_pkg::OP_SCAN, 8'h1E);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_PREFIX);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_LSHIFT_MAKE);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_PREFIX);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_PREFIX);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_CTRL_BRK);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_ALT_MAKE);
      send_beat(sc1kd_pkg::OP_SCAN, 8'h10);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_ALT_BRK);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_PREFIX);
      send_beat(sc1kd_pkg::OP_SCAN, 8'h48);
      send_beat(sc1kd_pkg::OP_SCAN, 8'h7F);
      send_beat(sc1kd_pkg::OP_SCAN, 8'hFF);
      send_beat(sc1kd_pkg::OP_SCAN, sc1kd_pkg::SC_CAPS);
      repeat (4) send_beat(sc1kd_pkg::OP_POP, 8'h00);

      random_end    = beats_sent + RANDOM_BEATS;
      segment_start = beats_sent;
      pop_percent   = 30;
      drained_once  = 1'b0;
      while (beats_sent < random_end) begin
         if (beats_sent - segment_start >= 60) begin
            segment_start = beats_sent;
            case ($urandom_range(0, 3))
               0: pop_percent = 5;
               1: pop_percent = 25;
               2: pop_percent = 50;
               default: pop_percent = 85;
            endcase
         end
         if (!drained_once && beats_sent >= random_end - RANDOM_BEATS / 2) begin
            drain_results();
            drained_once = 1'b1;
         end
         if (beats_sent >= random_end - QUIET_BEATS) begin
            quiet_phase = 1'b1;
         end
         if ($urandom_range(0, 99) < pop_percent) begin
            send_beat(sc1kd_pkg::OP_POP, 8'($urandom_range(0, 255)));
         end else begin
            type_key();
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Beats: %0d scan, %0d pop; events queued %0d, dropped %0d, popped %0d",
               sb.scan_beats, sb.pop_beats, sb.events_queued, sb.events_dropped,
               sb.events_popped);
      $display("Ring reached full %0d times; %0d field mismatches",
               sb.ring_fills, sb.errors);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
